// ----- hw/rtl/scl_pkg.sv -----
// Shared types, widths and test codes for the shape collision tester.
// Used by every stage module and by the top level; depends on nothing.
package scl_pkg;

   localparam int COORD_BITS = 24;
   localparam int SIZE_BITS  = COORD_BITS - 1;
   localparam int DIFF_BITS  = COORD_BITS + 3;
   localparam int OPND_BITS  = COORD_BITS + 1;
   localparam int SQR_BITS   = 2 * OPND_BITS;
   localparam int RAD_BITS   = COORD_BITS;
   localparam int MODE_BITS  = 4;

   localparam logic [MODE_BITS-1:0] MODE_RECT_IN_RECT = 4'd0;
   localparam logic [MODE_BITS-1:0] MODE_CIRC_IN_CIRC = 4'd1;
   localparam logic [MODE_BITS-1:0] MODE_CIRC_IN_RECT = 4'd2;
   localparam logic [MODE_BITS-1:0] MODE_RECT_IN_CIRC = 4'd3;
   localparam logic [MODE_BITS-1:0] MODE_RECT_RECT    = 4'd4;
   localparam logic [MODE_BITS-1:0] MODE_CIRC_CIRC    = 4'd5;
   localparam logic [MODE_BITS-1:0] MODE_RECT_CIRC    = 4'd6;
   localparam logic [MODE_BITS-1:0] MODE_PT_IN_RECT   = 4'd7;
   localparam logic [MODE_BITS-1:0] MODE_PT_IN_CIRC   = 4'd8;

   typedef logic signed [DIFF_BITS-1:0] diff_type;

   // how the last stage forms the answer
   typedef enum logic [1:0] {
      KIND_FIXED,
      KIND_LE,
      KIND_LT4
   } kind_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]         mode;
      logic signed [COORD_BITS-1:0] a_x;
      logic signed [COORD_BITS-1:0] a_y;
      logic [SIZE_BITS-1:0]         a_width;
      logic [SIZE_BITS-1:0]         a_height;
      logic [SIZE_BITS-1:0]         a_radius;
      logic signed [COORD_BITS-1:0] b_x;
      logic signed [COORD_BITS-1:0] b_y;
      logic [SIZE_BITS-1:0]         b_width;
      logic [SIZE_BITS-1:0]         b_height;
      logic [SIZE_BITS-1:0]         b_radius;
   } req_type;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      diff_type             dxa;
      diff_type             dya;
      diff_type             dxe;
      diff_type             dye;
      diff_type             dxb;
      diff_type             dyb;
      diff_type             dxeb;
      diff_type             dyeb;
      diff_type             qx;
      diff_type             qy;
      diff_type             tx;
      diff_type             ty;
      diff_type             ux;
      diff_type             uy;
      diff_type             rawx;
      diff_type             rawy;
      logic [SIZE_BITS-1:0] aw;
      logic [SIZE_BITS-1:0] ah;
      logic [RAD_BITS-1:0]  rad;
      logic                 rad_ok;
   } s1_type;

   typedef struct packed {
      kind_type             kind;
      logic                 fixed_hit;
      logic [OPND_BITS-1:0] m0;
      logic [OPND_BITS-1:0] m1;
      logic [OPND_BITS-1:0] m2;
      logic [OPND_BITS-1:0] m3;
      logic [OPND_BITS-1:0] m4;
   } s2_type;

   typedef struct packed {
      kind_type            kind;
      logic                fixed_hit;
      logic [SQR_BITS-1:0] sx0;
      logic [SQR_BITS-1:0] sy0;
      logic [SQR_BITS-1:0] sx1;
      logic [SQR_BITS-1:0] sy1;
      logic [SQR_BITS-1:0] sr;
   } s3_type;

endpackage

// ----- hw/rtl/scl_diff.sv -----
// Stage 1: edge, center and radius differences of the two shapes.
// Depends on scl_pkg.
module scl_diff
   import scl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    up_valid,
   output logic    up_ready,
   input  req_type up_data,
   output logic    dn_valid,
   input  logic    dn_ready,
   output s1_type  dn_data
);

   logic     valid_ff;
   logic     valid_in;
   s1_type   data_ff;
   s1_type   data_in;
   diff_type ax, ay, bx, by, aw, ah, bw, bh, ard, brd;
   logic [RAD_BITS-1:0] ar, br;

   always_comb begin
      ax  = {{(DIFF_BITS-COORD_BITS){up_data.a_x[COORD_BITS-1]}}, up_data.a_x};
      ay  = {{(DIFF_BITS-COORD_BITS){up_data.a_y[COORD_BITS-1]}}, up_data.a_y};
      bx  = {{(DIFF_BITS-COORD_BITS){up_data.b_x[COORD_BITS-1]}}, up_data.b_x};
      by  = {{(DIFF_BITS-COORD_BITS){up_data.b_y[COORD_BITS-1]}}, up_data.b_y};
      aw  = {{(DIFF_BITS-SIZE_BITS){1'b0}}, up_data.a_width};
      ah  = {{(DIFF_BITS-SIZE_BITS){1'b0}}, up_data.a_height};
      bw  = {{(DIFF_BITS-SIZE_BITS){1'b0}}, up_data.b_width};
      bh  = {{(DIFF_BITS-SIZE_BITS){1'b0}}, up_data.b_height};
      ard = {{(DIFF_BITS-SIZE_BITS){1'b0}}, up_data.a_radius};
      brd = {{(DIFF_BITS-SIZE_BITS){1'b0}}, up_data.b_radius};
      ar  = {1'b0, up_data.a_radius};
      br  = {1'b0, up_data.b_radius};

      data_in.mode = up_data.mode;
      data_in.dxa  = ax - bx;
      data_in.dya  = ay - by;
      data_in.dxe  = ax + aw - bx;
      data_in.dye  = ay + ah - by;
      data_in.dxb  = ax - bx - bw;
      data_in.dyb  = ay - by - bh;
      data_in.dxeb = ax + aw - bx - bw;
      data_in.dyeb = ay + ah - by - bh;
      // doubled coordinates: center offsets without half sizes
      data_in.qx   = ((ax - bx) <<< 1) - bw;
      data_in.qy   = ((ay - by) <<< 1) - bh;
      data_in.tx   = bw - (ard <<< 1);
      data_in.ty   = bh - (ard <<< 1);
      data_in.ux   = ((ax - bx) <<< 1) + aw;
      data_in.uy   = ((ay - by) <<< 1) + ah;
      data_in.rawx = (brd <<< 1) + aw;
      data_in.rawy = (brd <<< 1) + ah;
      data_in.aw   = up_data.a_width;
      data_in.ah   = up_data.a_height;

      unique case (up_data.mode)
         MODE_CIRC_IN_CIRC: begin
            data_in.rad    = br - ar;
            data_in.rad_ok = (ar <= br);
         end
         MODE_RECT_IN_CIRC, MODE_PT_IN_CIRC: begin
            data_in.rad    = br;
            data_in.rad_ok = 1'b1;
         end
         MODE_CIRC_CIRC: begin
            data_in.rad    = ar + br;
            data_in.rad_ok = 1'b1;
         end
         MODE_RECT_CIRC: begin
            data_in.rad    = br << 1;
            data_in.rad_ok = 1'b1;
         end
         default: begin
            data_in.rad    = '0;
            data_in.rad_ok = 1'b1;
         end
      endcase
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ----- hw/rtl/scl_select.sv -----
// Stage 2: sign tests, rectangle decisions and multiplier operand selection.
// Depends on scl_pkg.
module scl_select
   import scl_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   up_valid,
   output logic   up_ready,
   input  s1_type up_data,
   output logic   dn_valid,
   input  logic   dn_ready,
   output s2_type dn_data
);

   logic     valid_ff;
   logic     valid_in;
   s2_type   data_ff;
   s2_type   data_in;
   diff_type aw, ah, dx6, dy6, cx, cy;
   logic     in_ab, in_ba, open_hit, pt_hit, circ_hit, far, near;
   diff_type mx_a, my_a, mx_e, my_e;

   function automatic diff_type mag(input diff_type v);
      return v[DIFF_BITS-1] ? -v : v;
   endfunction

   always_comb begin
      aw  = {{(DIFF_BITS-SIZE_BITS){1'b0}}, up_data.aw};
      ah  = {{(DIFF_BITS-SIZE_BITS){1'b0}}, up_data.ah};
      dx6 = mag(up_data.ux);
      dy6 = mag(up_data.uy);
      cx  = dx6 - aw;
      cy  = dy6 - ah;
      far  = (dx6 > up_data.rawx) || (dy6 > up_data.rawy);
      near = (dx6 <= aw) || (dy6 <= ah);

      in_ab = (up_data.dxa >= 0) && (up_data.dxeb <= 0) &&
              (up_data.dya >= 0) && (up_data.dyeb <= 0);
      in_ba = (up_data.dxa <= 0) && (up_data.dxeb >= 0) &&
              (up_data.dya <= 0) && (up_data.dyeb >= 0);
      open_hit = (up_data.dxb < 0) && (up_data.dxe > 0) &&
                 (up_data.dyb < 0) && (up_data.dye > 0);
      pt_hit = (up_data.dxa >= 0) && (up_data.dxb <= 0) &&
               (up_data.dya >= 0) && (up_data.dyb <= 0);
      circ_hit = (up_data.qx < up_data.tx) && (up_data.qx > -up_data.tx) &&
                 (up_data.qy < up_data.ty) && (up_data.qy > -up_data.ty);

      mx_a = mag(up_data.dxa);
      my_a = mag(up_data.dya);
      mx_e = mag(up_data.dxe);
      my_e = mag(up_data.dye);

      data_in.m2 = mx_e[OPND_BITS-1:0];
      data_in.m3 = my_e[OPND_BITS-1:0];
      data_in.m4 = {1'b0, up_data.rad};
      if (up_data.mode == MODE_RECT_CIRC) begin
         data_in.m0 = cx[OPND_BITS-1:0];
         data_in.m1 = cy[OPND_BITS-1:0];
      end else begin
         data_in.m0 = mx_a[OPND_BITS-1:0];
         data_in.m1 = my_a[OPND_BITS-1:0];
      end

      unique case (up_data.mode)
         MODE_RECT_IN_RECT: begin
            data_in.kind      = KIND_FIXED;
            data_in.fixed_hit = in_ab;
         end
         MODE_CIRC_IN_CIRC: begin
            data_in.kind      = up_data.rad_ok ? KIND_LE : KIND_FIXED;
            data_in.fixed_hit = 1'b0;
         end
         MODE_CIRC_IN_RECT: begin
            data_in.kind      = KIND_FIXED;
            data_in.fixed_hit = circ_hit;
         end
         MODE_RECT_IN_CIRC: begin
            data_in.kind      = KIND_LT4;
            data_in.fixed_hit = 1'b0;
         end
         MODE_RECT_RECT: begin
            data_in.kind      = KIND_FIXED;
            data_in.fixed_hit = open_hit || in_ab || in_ba;
         end
         MODE_CIRC_CIRC, MODE_PT_IN_CIRC: begin
            data_in.kind      = KIND_LE;
            data_in.fixed_hit = 1'b0;
         end
         MODE_RECT_CIRC: begin
            data_in.kind      = (far || near) ? KIND_FIXED : KIND_LE;
            data_in.fixed_hit = !far && near;
         end
         MODE_PT_IN_RECT: begin
            data_in.kind      = KIND_FIXED;
            data_in.fixed_hit = pt_hit;
         end
         default: begin
            data_in.kind      = KIND_FIXED;
            data_in.fixed_hit = 1'b0;
         end
      endcase
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ----- hw/rtl/scl_square.sv -----
// Stage 3: the five squares of distance and radius terms.
// Depends on scl_pkg.
module scl_square
   import scl_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   up_valid,
   output logic   up_ready,
   input  s2_type up_data,
   output logic   dn_valid,
   input  logic   dn_ready,
   output s3_type dn_data
);

   logic   valid_ff;
   logic   valid_in;
   s3_type data_ff;
   s3_type data_in;

   always_comb begin
      data_in.kind      = up_data.kind;
      data_in.fixed_hit = up_data.fixed_hit;
      data_in.sx0       = up_data.m0 * up_data.m0;
      data_in.sy0       = up_data.m1 * up_data.m1;
      data_in.sx1       = up_data.m2 * up_data.m2;
      data_in.sy1       = up_data.m3 * up_data.m3;
      data_in.sr        = up_data.m4 * up_data.m4;
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ----- hw/rtl/scl_decide.sv -----
// Stage 4: sums of squares against the squared radius, final hit register.
// Depends on scl_pkg.
module scl_decide
   import scl_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   up_valid,
   output logic   up_ready,
   input  s3_type up_data,
   output logic   dn_valid,
   input  logic   dn_ready,
   output logic   dn_hit
);

   logic              valid_ff;
   logic              valid_in;
   logic              hit_ff;
   logic              hit_in;
   logic [SQR_BITS:0] d00, d10, d01, d11, r2;

   always_comb begin
      d00 = {1'b0, up_data.sx0} + {1'b0, up_data.sy0};
      d10 = {1'b0, up_data.sx1} + {1'b0, up_data.sy0};
      d01 = {1'b0, up_data.sx0} + {1'b0, up_data.sy1};
      d11 = {1'b0, up_data.sx1} + {1'b0, up_data.sy1};
      r2  = {1'b0, up_data.sr};
      unique case (up_data.kind)
         KIND_LE:  hit_in = (d00 <= r2);
         KIND_LT4: hit_in = (d00 < r2) && (d10 < r2) && (d01 < r2) && (d11 < r2);
         default:  hit_in = up_data.fixed_hit;
      endcase
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         hit_ff <= hit_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_hit   = hit_ff;

endmodule

// ----- hw/rtl/shape_collision_tester.sv -----
// Shape collision tester top level: four-stage pipeline of scl_diff,
// scl_select, scl_square and scl_decide. Depends on scl_pkg.
//
// Takes one request per cycle while rsp_ready is held high and returns one
// hit bit per request, in order. Each stage holds one request with its own
// valid bit; a stage loads whenever it is empty or the stage after it is
// moving, so bubbles close up and a stalled output holds the whole chain
// without loss. The squaring stage (five 25x25 multipliers) and the
// sum-and-compare stage set the clock rate.
module shape_collision_tester
   import scl_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [MODE_BITS-1:0]         req_mode,
   input  logic signed [COORD_BITS-1:0] req_a_x,
   input  logic signed [COORD_BITS-1:0] req_a_y,
   input  logic [SIZE_BITS-1:0]         req_a_width,
   input  logic [SIZE_BITS-1:0]         req_a_height,
   input  logic [SIZE_BITS-1:0]         req_a_radius,
   input  logic signed [COORD_BITS-1:0] req_b_x,
   input  logic signed [COORD_BITS-1:0] req_b_y,
   input  logic [SIZE_BITS-1:0]         req_b_width,
   input  logic [SIZE_BITS-1:0]         req_b_height,
   input  logic [SIZE_BITS-1:0]         req_b_radius,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit
);

   req_type req;
   s1_type  s1_data;
   s2_type  s2_data;
   s3_type  s3_data;
   logic    s1_valid, s1_ready;
   logic    s2_valid, s2_ready;
   logic    s3_valid, s3_ready;

   always_comb begin
      req.mode     = req_mode;
      req.a_x      = req_a_x;
      req.a_y      = req_a_y;
      req.a_width  = req_a_width;
      req.a_height = req_a_height;
      req.a_radius = req_a_radius;
      req.b_x      = req_b_x;
      req.b_y      = req_b_y;
      req.b_width  = req_b_width;
      req.b_height = req_b_height;
      req.b_radius = req_b_radius;
   end

   scl_diff u_diff (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .up_data  (req),
      .dn_valid (s1_valid),
      .dn_ready (s1_ready),
      .dn_data  (s1_data)
   );

   scl_select u_select (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s1_valid),
      .up_ready (s1_ready),
      .up_data  (s1_data),
      .dn_valid (s2_valid),
      .dn_ready (s2_ready),
      .dn_data  (s2_data)
   );

   scl_square u_square (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s2_valid),
      .up_ready (s2_ready),
      .up_data  (s2_data),
      .dn_valid (s3_valid),
      .dn_ready (s3_ready),
      .dn_data  (s3_data)
   );

   scl_decide u_decide (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s3_valid),
      .up_ready (s3_ready),
      .up_data  (s3_data),
      .dn_valid (rsp_valid),
      .dn_ready (rsp_ready),
      .dn_hit   (rsp_hit)
   );

endmodule
